// File: sv/brf_pkg.sv
`timescale 1ns / 1ps

package brf_pkg;

    localparam int STEP_W = 4;
    localparam int OP_W   = 4;
    localparam int HOLD_W = 3;
    localparam int JMP_W  = 3;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR     = 4'd1;
    localparam logic [OP_W-1:0] OP_ACCEPT    = 4'd2;
    localparam logic [OP_W-1:0] OP_ORDER     = 4'd3;
    localparam logic [OP_W-1:0] OP_LOAD      = 4'd4;
    localparam logic [OP_W-1:0] OP_CLIP      = 4'd5;
    localparam logic [OP_W-1:0] OP_INIT      = 4'd6;
    localparam logic [OP_W-1:0] OP_WRITE     = 4'd7;
    localparam logic [OP_W-1:0] OP_NEXT_PASS = 4'd8;
    localparam logic [OP_W-1:0] OP_RD_ISSUE  = 4'd9;
    localparam logic [OP_W-1:0] OP_OUT_LOAD  = 4'd10;

    // stay on the current step while the condition holds
    localparam logic [HOLD_W-1:0] H_NONE     = 3'd0;
    localparam logic [HOLD_W-1:0] H_NO_IN    = 3'd1;
    localparam logic [HOLD_W-1:0] H_CLR_BUSY = 3'd2;
    localparam logic [HOLD_W-1:0] H_PIX_BUSY = 3'd3;
    localparam logic [HOLD_W-1:0] H_OUT_BUSY = 3'd4;

    // jump conditions
    localparam logic [JMP_W-1:0] J_NONE   = 3'd0;
    localparam logic [JMP_W-1:0] J_ALWAYS = 3'd1;
    localparam logic [JMP_W-1:0] J_READ   = 3'd2;
    localparam logic [JMP_W-1:0] J_EMPTY  = 3'd3;
    localparam logic [JMP_W-1:0] J_BORDER = 3'd4;

    // program steps
    localparam logic [STEP_W-1:0] STEP_CLEAR     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ORDER     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LOAD      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CLIP      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_INIT      = 4'd5;
    localparam logic [STEP_W-1:0] STEP_WRITE     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_NEXT_PASS = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DONE      = 4'd8;
    localparam logic [STEP_W-1:0] STEP_RD        = 4'd9;
    localparam logic [STEP_W-1:0] STEP_RD_OUT    = 4'd10;

    localparam logic [0:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [0:0] REG_CANVAS_HEIGHT = 1'd1;

    localparam logic [8:0]  CANVAS_RESET = 9'd256;
    localparam logic [23:0] PIXEL_WHITE  = 24'hFFFFFF;
    localparam logic [23:0] PIXEL_BLACK  = 24'h000000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [HOLD_W-1:0] hold;
        logic [JMP_W-1:0]  jmp;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic is_read;
        logic clr_last;
        logic pix_last;
        logic out_busy;
        logic empty;
        logic border;
    } brf_flags_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            STEP_CLEAR:     w = '{OP_CLEAR,     H_CLR_BUSY, J_NONE,   STEP_IDLE};
            STEP_IDLE:      w = '{OP_ACCEPT,    H_NO_IN,    J_READ,   STEP_RD};
            STEP_ORDER:     w = '{OP_ORDER,     H_NONE,     J_NONE,   STEP_IDLE};
            STEP_LOAD:      w = '{OP_LOAD,      H_NONE,     J_NONE,   STEP_IDLE};
            STEP_CLIP:      w = '{OP_CLIP,      H_NONE,     J_NONE,   STEP_IDLE};
            STEP_INIT:      w = '{OP_INIT,      H_NONE,     J_EMPTY,  STEP_NEXT_PASS};
            STEP_WRITE:     w = '{OP_WRITE,     H_PIX_BUSY, J_NONE,   STEP_IDLE};
            STEP_NEXT_PASS: w = '{OP_NEXT_PASS, H_NONE,     J_BORDER, STEP_LOAD};
            STEP_DONE:      w = '{OP_NONE,      H_NONE,     J_ALWAYS, STEP_IDLE};
            STEP_RD:        w = '{OP_RD_ISSUE,  H_NONE,     J_NONE,   STEP_IDLE};
            STEP_RD_OUT:    w = '{OP_OUT_LOAD,  H_OUT_BUSY, J_ALWAYS, STEP_IDLE};
            default:        w = '{OP_NONE,      H_NONE,     J_ALWAYS, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: sv/bordered_rectangle_fill_top.sv
`timescale 1ns / 1ps

// channel   | direction | fields
// s_*       | in        | tuser: opcode; tdata: corner_a_x, corner_a_y, corner_b_x,
//           |           |   corner_b_y, fill_red, fill_green, fill_blue
// m_*       | out       | tuser: out_of_canvas; tdata: pixel_red, pixel_green, pixel_blue
// cfg_*     | in        | index 0 canvas_width, index 1 canvas_height
//
// a draw orders the corners, then loads, clips and writes the border area and then
// the fill area, one pixel a cycle, set by the single write port of the frame store.
// a read goes through accept, a registered store read and the output load.
// after reset a clearing pass writes white over the store, MAX_HEIGHT rows of
// 2**clog2(MAX_WIDTH) entries, one a cycle; no item is accepted meanwhile. a read
// result waits in the output register while m_tready is low; the next item is
// accepted meanwhile and a later read waits for it.

module bordered_rectangle_fill_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                                   // fill_red, fill_green, fill_blue
    input  logic [0:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pixel_red, pixel_green, pixel_blue
    output logic [0:0]  m_tuser,   // out_of_canvas
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_wdata
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = MAX_HEIGHT << XW;

    brf_pkg::ucode_t     word;
    brf_pkg::brf_flags_t flags;

    logic [8:0]  canvas_w_reg;
    logic [8:0]  canvas_h_reg;
    logic [12:0] eff_w;
    logic [12:0] eff_h;
    logic signed [12:0] eff_w_m1;
    logic signed [12:0] eff_h_m1;

    logic signed [11:0] a_x_reg;
    logic signed [11:0] a_y_reg;
    logic signed [11:0] b_x_reg;
    logic signed [11:0] b_y_reg;
    logic [23:0]        colour_reg;
    logic signed [12:0] a_x13;
    logic signed [12:0] a_y13;
    logic signed [12:0] b_x13;
    logic signed [12:0] b_y13;

    logic signed [12:0] ord_lx_reg;
    logic signed [12:0] ord_ly_reg;
    logic signed [12:0] ord_hx_reg;
    logic signed [12:0] ord_hy_reg;
    logic signed [12:0] lo_x_reg;
    logic signed [12:0] lo_y_reg;
    logic signed [12:0] hi_x_reg;
    logic signed [12:0] hi_y_reg;
    logic signed [12:0] grow;

    logic [XW-1:0] cur_x_reg;
    logic [YW-1:0] cur_y_reg;
    logic [AW-1:0] clr_reg;
    logic          pass_reg;
    logic          oob_reg;

    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;
    logic        mem_we;
    logic [AW-1:0] waddr;
    logic [23:0] wdata;
    logic [AW-1:0] raddr;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        out_busy;
    logic        out_load;

    brf_ucode u_ucode (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .word  (word)
    );

    // canvas limited to the store size
    assign eff_w = ({4'd0, canvas_w_reg} > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : {4'd0, canvas_w_reg};
    assign eff_h = ({4'd0, canvas_h_reg} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, canvas_h_reg};
    assign eff_w_m1 = $signed(eff_w) - 13'sd1;
    assign eff_h_m1 = $signed(eff_h) - 13'sd1;

    assign a_x13 = {a_x_reg[11], a_x_reg};
    assign a_y13 = {a_y_reg[11], a_y_reg};
    assign b_x13 = {b_x_reg[11], b_x_reg};
    assign b_y13 = {b_y_reg[11], b_y_reg};
    assign grow  = {12'd0, !pass_reg};

    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = (word.op == brf_pkg::OP_OUT_LOAD) && !out_busy;
    assign s_tready = (word.op == brf_pkg::OP_ACCEPT);

    assign flags.in_valid = s_tvalid;
    assign flags.is_read  = s_tuser[0];
    assign flags.clr_last = (clr_reg == AW'(DEPTH - 1));
    assign flags.pix_last = (cur_x_reg == hi_x_reg[XW-1:0]) && (cur_y_reg == hi_y_reg[YW-1:0]);
    assign flags.out_busy = out_busy;
    assign flags.empty    = (lo_x_reg > hi_x_reg) || (lo_y_reg > hi_y_reg);
    assign flags.border   = !pass_reg;

    assign mem_we = (word.op == brf_pkg::OP_CLEAR) || (word.op == brf_pkg::OP_WRITE);
    assign waddr  = (word.op == brf_pkg::OP_CLEAR) ? clr_reg : {cur_y_reg, cur_x_reg};
    assign wdata  = (word.op == brf_pkg::OP_CLEAR) ? brf_pkg::PIXEL_WHITE
                  : (pass_reg ? colour_reg : brf_pkg::PIXEL_BLACK);
    assign raddr  = {a_y_reg[YW-1:0], a_x_reg[XW-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (word.op == brf_pkg::OP_RD_ISSUE)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_w_reg <= brf_pkg::CANVAS_RESET;
            canvas_h_reg <= brf_pkg::CANVAS_RESET;
            clr_reg      <= '0;
            pass_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == brf_pkg::REG_CANVAS_WIDTH)
            begin
                canvas_w_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == brf_pkg::REG_CANVAS_HEIGHT)
            begin
                canvas_h_reg <= cfg_wdata;
            end
            if (word.op == brf_pkg::OP_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (word.op == brf_pkg::OP_ORDER)
            begin
                pass_reg <= 1'b0;
            end
            else if (word.op == brf_pkg::OP_NEXT_PASS)
            begin
                pass_reg <= 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (word.op)
            brf_pkg::OP_ACCEPT:
            begin
                if (s_tvalid)
                begin
                    a_x_reg    <= s_tdata[11:0];
                    a_y_reg    <= s_tdata[23:12];
                    b_x_reg    <= s_tdata[35:24];
                    b_y_reg    <= s_tdata[47:36];
                    colour_reg <= {s_tdata[55:48], s_tdata[63:56], s_tdata[71:64]};
                end
            end
            brf_pkg::OP_ORDER:
            begin
                ord_lx_reg <= (a_x13 < b_x13) ? a_x13 : b_x13;
                ord_hx_reg <= (a_x13 < b_x13) ? b_x13 : a_x13;
                ord_ly_reg <= (a_y13 < b_y13) ? a_y13 : b_y13;
                ord_hy_reg <= (a_y13 < b_y13) ? b_y13 : a_y13;
            end
            brf_pkg::OP_LOAD:
            begin
                // border pass grows the box by one pixel per side
                lo_x_reg <= ord_lx_reg - grow;
                lo_y_reg <= ord_ly_reg - grow;
                hi_x_reg <= ord_hx_reg + grow;
                hi_y_reg <= ord_hy_reg + grow;
            end
            brf_pkg::OP_CLIP:
            begin
                lo_x_reg <= (lo_x_reg < 13'sd0) ? 13'sd0 : lo_x_reg;
                lo_y_reg <= (lo_y_reg < 13'sd0) ? 13'sd0 : lo_y_reg;
                hi_x_reg <= (hi_x_reg > eff_w_m1) ? eff_w_m1 : hi_x_reg;
                hi_y_reg <= (hi_y_reg > eff_h_m1) ? eff_h_m1 : hi_y_reg;
            end
            brf_pkg::OP_INIT:
            begin
                cur_x_reg <= lo_x_reg[XW-1:0];
                cur_y_reg <= lo_y_reg[YW-1:0];
            end
            brf_pkg::OP_WRITE:
            begin
                if (cur_x_reg == hi_x_reg[XW-1:0])
                begin
                    cur_x_reg <= lo_x_reg[XW-1:0];
                    cur_y_reg <= cur_y_reg + 1'b1;
                end
                else
                begin
                    cur_x_reg <= cur_x_reg + 1'b1;
                end
            end
            brf_pkg::OP_RD_ISSUE:
            begin
                oob_reg <= (a_x13 < 13'sd0) || (a_y13 < 13'sd0)
                        || (a_x13 >= $signed(eff_w)) || (a_y13 >= $signed(eff_h));
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            // store holds red in the top byte; the stream carries red first
            m_tdata_reg <= oob_reg ? 24'd0 : {rdata_reg[7:0], rdata_reg[15:8], rdata_reg[23:16]};
            m_tuser_reg <= oob_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// File: sv/brf_ucode.sv
`timescale 1ns / 1ps

module brf_ucode (
    input  logic                clk,
    input  logic                rst_n,
    input  brf_pkg::brf_flags_t flags,
    output brf_pkg::ucode_t     word
);

    logic [brf_pkg::STEP_W-1:0] step_reg;
    logic [brf_pkg::STEP_W-1:0] step_next;
    logic                       hold_hit;
    logic                       jmp_hit;

    assign word = brf_pkg::ucode_rom(step_reg);

    always_comb
    begin
        case (word.hold)
            brf_pkg::H_NO_IN:    hold_hit = !flags.in_valid;
            brf_pkg::H_CLR_BUSY: hold_hit = !flags.clr_last;
            brf_pkg::H_PIX_BUSY: hold_hit = !flags.pix_last;
            brf_pkg::H_OUT_BUSY: hold_hit = flags.out_busy;
            default:             hold_hit = 1'b0;
        endcase
        case (word.jmp)
            brf_pkg::J_ALWAYS: jmp_hit = 1'b1;
            brf_pkg::J_READ:   jmp_hit = flags.is_read;
            brf_pkg::J_EMPTY:  jmp_hit = flags.empty;
            brf_pkg::J_BORDER: jmp_hit = flags.border;
            default:           jmp_hit = 1'b0;
        endcase
        if (hold_hit)
        begin
            step_next = step_reg;
        end
        else if (jmp_hit)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= brf_pkg::STEP_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: tb/sv/frame_read_checker.sv
`timescale 1ns / 1ps

module frame_read_checker #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                                   // fill_red, fill_green, fill_blue
    input  logic [0:0]  s_tuser,   // opcode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic [0:0]  m_tuser,   // out_of_canvas
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [8:0]  cfg_wdata,
    output int          outstanding,
    output int          fail_count
);

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       off_canvas;
    } pixel_read_t;

    logic [23:0] frame_model [MAX_WIDTH*MAX_HEIGHT];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    pixel_read_t pending_reads [$];
    int          fails;

    function automatic int usable_cols();
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int usable_rows();
        return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    function automatic void paint_box(int left, int top, int right, int bottom,
                                      logic [23:0] rgb);
        int x;
        int y;
        if (left < 0)
            left = 0;
        if (top < 0)
            top = 0;
        if (right > usable_cols() - 1)
            right = usable_cols() - 1;
        if (bottom > usable_rows() - 1)
            bottom = usable_rows() - 1;
        for (y = top; y <= bottom; y++)
        begin
            for (x = left; x <= right; x++)
            begin
                frame_model[y * MAX_WIDTH + x] = rgb;
            end
        end
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_read_t want;
        int          ax;
        int          ay;
        int          bx;
        int          by;
        int          left;
        int          right;
        int          top;
        int          bottom;
        logic [23:0] pix;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH * MAX_HEIGHT; i++)
            begin
                frame_model[i] = brf_pkg::PIXEL_WHITE;
            end
            width_reg  = brf_pkg::CANVAS_RESET;
            height_reg = brf_pkg::CANVAS_RESET;
            pending_reads.delete();
            fails = 0;
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_reads.size() == 0)
                begin
                    $error("pixel item with no read pending: tdata %h, tuser %0d",
                           m_tdata, m_tuser);
                    fails++;
                end
                else
                begin
                    want = pending_reads.pop_front();
                    check_field("pixel_red", want.red, m_tdata[7:0]);
                    check_field("pixel_green", want.green, m_tdata[15:8]);
                    check_field("pixel_blue", want.blue, m_tdata[23:16]);
                    check_field("out_of_canvas", {7'd0, want.off_canvas}, {7'd0, m_tuser[0]});
                end
            end

            if (s_tvalid && s_tready)
            begin
                ax = $signed(s_tdata[11:0]);
                ay = $signed(s_tdata[23:12]);
                bx = $signed(s_tdata[35:24]);
                by = $signed(s_tdata[47:36]);
                // tuser high marks a pixel read, low a rectangle draw
                if (s_tuser[0])
                begin
                    if (ax < 0 || ay < 0 || ax >= usable_cols() || ay >= usable_rows())
                    begin
                        want = '{8'd0, 8'd0, 8'd0, 1'b1};
                    end
                    else
                    begin
                        pix  = frame_model[ay * MAX_WIDTH + ax];
                        want = '{pix[23:16], pix[15:8], pix[7:0], 1'b0};
                    end
                    pending_reads.push_back(want);
                end
                else
                begin
                    left   = (ax < bx) ? ax : bx;
                    right  = (ax < bx) ? bx : ax;
                    top    = (ay < by) ? ay : by;
                    bottom = (ay < by) ? by : ay;
                    paint_box(left - 1, top - 1, right + 1, bottom + 1,
                              brf_pkg::PIXEL_BLACK);
                    paint_box(left, top, right, bottom,
                              {s_tdata[55:48], s_tdata[63:56], s_tdata[71:64]});
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == brf_pkg::REG_CANVAS_WIDTH)
                    width_reg = cfg_wdata;
                else if (cfg_index == brf_pkg::REG_CANVAS_HEIGHT)
                    height_reg = cfg_wdata;
            end

            outstanding <= pending_reads.size();
            fail_count  <= fails;
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int FB_W        = 256;
    localparam int FB_H        = 256;
    localparam int STALL_LIMIT = 500000;
    localparam int PHASES      = 8;

    localparam logic OPC_DRAW = 1'b0;
    localparam logic OPC_READ = 1'b1;

    // canvas settings and random item counts, one entry per phase
    localparam int PHASE_W [PHASES] = '{1, 256, 0, 9, 511, 37, 256, 64};
    localparam int PHASE_H [PHASES] = '{256, 1, 7, 0, 300, 21, 256, 200};
    localparam int PHASE_N [PHASES] = '{50, 50, 20, 20, 100, 100, 120, 100};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [8:0]  cfg_wdata;

    int outstanding;
    int fail_count;
    int send_idle_pct = 22;
    int recv_idle_pct = 84;
    int items_sent    = 0;
    int quiet_cycles  = 0;
    int span_w        = FB_W;
    int span_h        = FB_H;
    int box_l         = 0;
    int box_t         = 0;
    int box_r         = 0;
    int box_b         = 0;

    bordered_rectangle_fill_top #(
        .MAX_WIDTH  (FB_W),
        .MAX_HEIGHT (FB_H)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    frame_read_checker #(
        .MAX_WIDTH  (FB_W),
        .MAX_HEIGHT (FB_H)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ends the run when neither channel moves an item for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [11:0] to_coord(int v);
        if (v < -2048)
            v = -2048;
        else if (v > 2047)
            v = 2047;
        return v[11:0];
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(4095)) - 2048;
    endfunction

    function automatic logic [71:0] pack_item(int ax, int ay, int bx, int by,
                                              logic [23:0] rgb);
        return {rgb[7:0], rgb[15:8], rgb[23:16],
                to_coord(by), to_coord(bx), to_coord(ay), to_coord(ax)};
    endfunction

    task automatic push_item(logic op, logic [71:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        items_sent++;
        if (items_sent == 195)
        begin
            send_idle_pct <= 84;
            recv_idle_pct <= 22;
        end
        else if (items_sent == 390)
        begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
    endtask

    task automatic draw_box(int ax, int ay, int bx, int by, logic [23:0] rgb);
        box_l = (ax < bx) ? ax : bx;
        box_r = (ax < bx) ? bx : ax;
        box_t = (ay < by) ? ay : by;
        box_b = (ay < by) ? by : ay;
        push_item(OPC_DRAW, pack_item(ax, ay, bx, by, rgb));
    endtask

    // the second corner and the colour of a read are ignored, so they carry noise
    task automatic read_pixel(int x, int y);
        push_item(OPC_READ, pack_item(x, y, any_coord(), any_coord(), 24'($urandom)));
    endtask

    // a read waits behind any draw still running, so its result marks the block idle
    task automatic settle();
        read_pixel(int'($urandom_range(span_w - 1)), int'($urandom_range(span_h - 1)));
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_canvas(int w, int h);
        cfg_we    <= 1'b1;
        cfg_index <= brf_pkg::REG_CANVAS_WIDTH;
        cfg_wdata <= w[8:0];
        @(posedge clk);
        cfg_index <= brf_pkg::REG_CANVAS_HEIGHT;
        cfg_wdata <= h[8:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        span_w = (w == 0) ? 1 : ((w > FB_W) ? FB_W : w);
        span_h = (h == 0) ? 1 : ((h > FB_H) ? FB_H : h);
    endtask

    task automatic random_items(int count);
        int pick;
        int ax;
        int ay;
        for (int i = 0; i < count; i++)
        begin
            pick = int'($urandom_range(99));
            if (pick < 40)
            begin
                // small box around the canvas, often hanging over an edge
                ax = int'($urandom_range(span_w + 11)) - 6;
                ay = int'($urandom_range(span_h + 11)) - 6;
                draw_box(ax, ay, ax + int'($urandom_range(24)) - 12,
                         ay + int'($urandom_range(24)) - 12, 24'($urandom));
            end
            else if (pick < 50)
            begin
                ax = any_coord();
                ay = any_coord();
                draw_box(ax, ay, ax + int'($urandom_range(16)) - 8,
                         ay + int'($urandom_range(16)) - 8, 24'($urandom));
            end
            else if (pick < 80)
            begin
                // probe the last box, its border and the pixels just outside
                read_pixel(box_l - 2 + int'($urandom_range(box_r - box_l + 4)),
                           box_t - 2 + int'($urandom_range(box_b - box_t + 4)));
            end
            else if (pick < 93)
            begin
                read_pixel(int'($urandom_range(span_w - 1)), int'($urandom_range(span_h - 1)));
            end
            else
            begin
                read_pixel(any_coord(), any_coord());
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OPC_DRAW;
        cfg_we    <= 1'b0;
        cfg_index <= brf_pkg::REG_CANVAS_WIDTH;
        cfg_wdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // cleared store, canvas edges and reads far outside
        read_pixel(0, 0);
        read_pixel(255, 255);
        read_pixel(256, 0);
        read_pixel(0, 256);
        read_pixel(-1, 5);
        read_pixel(-2048, -2048);
        read_pixel(2047, 2047);

        // corners given in reverse order
        draw_box(20, 15, 10, 5, 24'h123456);
        read_pixel(10, 5);
        read_pixel(20, 15);
        read_pixel(9, 5);
        read_pixel(21, 16);
        read_pixel(22, 17);

        // box off the canvas whose border still touches the corner pixel
        draw_box(-1, -1, -1, -1, 24'hABCDEF);
        read_pixel(0, 0);

        // single pixel at the far corner, border clipped on two sides
        draw_box(255, 255, 255, 255, 24'hFF00FF);
        read_pixel(255, 255);
        read_pixel(254, 254);

        // empty after clipping, then the widest box there is
        draw_box(2047, -2048, 2047, -2048, 24'h00FF00);
        draw_box(-2048, -2048, 2047, 2047, 24'h00FF80);
        read_pixel(128, 128);
        read_pixel(0, 255);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            set_canvas(PHASE_W[p], PHASE_H[p]);
            random_items(PHASE_N[p]);
            settle();
        end

        repeat (50) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
